[rtl/core/hmbd_pkg.sv]
// Package of types and constants shared by the handheld memory bus decoder modules.
package hmbd_pkg;

	localparam int unsigned WRAM_DEPTH = 8192;
	localparam int unsigned WRAM_AW    = $clog2(WRAM_DEPTH);
	localparam int unsigned SMALL_DEPTH = 128;
	localparam int unsigned SMALL_AW    = $clog2(SMALL_DEPTH);

	localparam logic [15:0] ROM_END     = 16'h7FFF;
	localparam logic [15:0] BOOT_END    = 16'h00FF;
	localparam logic [15:0] VRAM_END    = 16'h9FFF;
	localparam logic [15:0] XRAM_END    = 16'hBFFF;
	localparam logic [15:0] ECHO_END    = 16'hFDFF;
	localparam logic [15:0] OAM_END     = 16'hFEFF;
	localparam logic [15:0] JOYPAD_ADDR = 16'hFF00;

	localparam logic [7:0] OAM_LO_END   = 8'h9F;
	localparam logic [7:0] TIMER_LO     = 8'h04;
	localparam logic [7:0] TIMER_HI     = 8'h07;
	localparam logic [7:0] SOUND_LO     = 8'h10;
	localparam logic [7:0] SOUND_HI     = 8'h3F;
	localparam logic [7:0] LCD_LO       = 8'h40;
	localparam logic [7:0] LCD_HI       = 8'h4B;
	localparam logic [7:0] IO_LAST      = 8'h7F;
	localparam logic [7:0] HRAM_LAST    = 8'hFE;

	localparam logic [SMALL_AW-1:0] IO_BOOT_IDX   = 7'h50;
	localparam logic [SMALL_AW-1:0] IO_JOYPAD_IDX = 7'h00;

	localparam logic [7:0] IE_RESET    = 8'hFF;
	localparam logic [7:0] UNUSED_BYTE = 8'hFF;

	typedef enum logic [2:0] {
		TGT_LOCAL  = 3'd0,
		TGT_MAPPER = 3'd1,
		TGT_VIDEO  = 3'd2,
		TGT_TIMER  = 3'd3,
		TGT_SOUND  = 3'd4,
		TGT_BOOT   = 3'd5,
		TGT_IGNORE = 3'd6
	} tgt_t;

	typedef enum logic [2:0] {
		AREA_NONE   = 3'd0,
		AREA_WRAM   = 3'd1,
		AREA_HRAM   = 3'd2,
		AREA_IO     = 3'd3,
		AREA_IE     = 3'd4,
		AREA_UNUSED = 3'd5
	} area_t;

	typedef struct packed {
		tgt_t               tgt;
		area_t              area;
		logic [WRAM_AW-1:0] idx;
	} dec_t;

	typedef struct packed {
		logic               en;
		area_t              area;
		logic [WRAM_AW-1:0] idx;
		logic [7:0]         data;
	} wr_req_t;

endpackage

[rtl/core/hmbd_decode.sv]
// Address decoder: picks the routed target and the local storage area of one access.
module hmbd_decode
	import hmbd_pkg::*;
(
	input  logic        write,
	input  logic [15:0] address,
	input  logic        boot_off,
	output dec_t        dec
);

	logic [7:0] lo;

	assign lo = address[7:0];

	always_comb begin
		dec.tgt  = TGT_LOCAL;
		dec.area = AREA_NONE;
		dec.idx  = address[WRAM_AW-1:0];
		priority if (address <= ROM_END) begin
			if (!write && !boot_off && address <= BOOT_END) begin
				dec.tgt = TGT_BOOT;
			end else begin
				dec.tgt = TGT_MAPPER;
			end
		end else if (address <= VRAM_END) begin
			dec.tgt = TGT_VIDEO;
		end else if (address <= XRAM_END) begin
			dec.tgt = TGT_MAPPER;
		end else if (address <= ECHO_END) begin
			// Work RAM and its echo share the low thirteen address bits.
			dec.area = AREA_WRAM;
		end else if (address <= OAM_END) begin
			if (lo <= OAM_LO_END) begin
				dec.tgt = TGT_VIDEO;
			end else if (write) begin
				dec.tgt = TGT_IGNORE;
			end else begin
				dec.area = AREA_UNUSED;
			end
		end else if (lo >= TIMER_LO && lo <= TIMER_HI) begin
			dec.tgt = TGT_TIMER;
		end else if (lo >= SOUND_LO && lo <= SOUND_HI) begin
			dec.tgt = TGT_SOUND;
		end else if (lo >= LCD_LO && lo <= LCD_HI) begin
			dec.tgt = TGT_VIDEO;
		end else if (lo <= IO_LAST) begin
			dec.area = AREA_IO;
		end else if (lo <= HRAM_LAST) begin
			dec.area = AREA_HRAM;
		end else begin
			dec.area = AREA_IE;
		end
	end

endmodule

[rtl/core/hmbd_store.sv]
// Local storage: work RAM, high RAM, I/O registers and the interrupt-enable register.
module hmbd_store
	import hmbd_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               rd_en,
	input  area_t              rd_area,
	input  logic [WRAM_AW-1:0] rd_idx,
	output logic [7:0]         rd_data,
	input  wr_req_t            wr,
	output logic               boot_off
);

	logic [7:0] wram_mem [WRAM_DEPTH];
	logic [7:0] hram_mem [SMALL_DEPTH];
	logic [7:0] io_mem   [SMALL_DEPTH];

	logic [SMALL_DEPTH-1:0] io_vld_q;
	logic [7:0]             ie_q;
	logic                   boot_off_q;

	logic [7:0] wram_rd_s1;
	logic [7:0] hram_rd_s1;
	logic [7:0] io_rd_s1;
	logic [7:0] ie_rd_s1;
	logic       io_vld_s1;
	area_t      area_s1;

	logic [SMALL_AW-1:0] rd_sidx;
	logic [SMALL_AW-1:0] wr_sidx;

	assign rd_sidx = rd_idx[SMALL_AW-1:0];
	assign wr_sidx = wr.idx[SMALL_AW-1:0];

	always_ff @(posedge clk) begin
		if (wr.en && wr.area == AREA_WRAM) begin
			wram_mem[wr.idx] <= wr.data;
		end
		if (wr.en && wr.area == AREA_HRAM) begin
			hram_mem[wr_sidx] <= wr.data;
		end
		if (wr.en && wr.area == AREA_IO) begin
			io_mem[wr_sidx] <= wr.data;
		end
		if (rd_en) begin
			wram_rd_s1 <= wram_mem[rd_idx];
			hram_rd_s1 <= hram_mem[rd_sidx];
			io_rd_s1   <= io_mem[rd_sidx];
			ie_rd_s1   <= ie_q;
			io_vld_s1  <= io_vld_q[rd_sidx];
			area_s1    <= rd_area;
		end
	end

	// The I/O register valid bits reset to zero: an entry never written reads as zero.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			io_vld_q   <= '0;
			ie_q       <= IE_RESET;
			boot_off_q <= 1'b0;
		end else if (wr.en) begin
			if (wr.area == AREA_IO) begin
				io_vld_q[wr_sidx] <= 1'b1;
				if (wr_sidx == IO_BOOT_IDX) begin
					boot_off_q <= (wr.data != 8'h00);
				end
			end
			if (wr.area == AREA_IE) begin
				ie_q <= wr.data;
			end
		end
	end

	always_comb begin
		unique case (area_s1)
			AREA_WRAM:   rd_data = wram_rd_s1;
			AREA_HRAM:   rd_data = hram_rd_s1;
			AREA_IO:     rd_data = io_vld_s1 ? io_rd_s1 : 8'h00;
			AREA_IE:     rd_data = ie_rd_s1;
			AREA_UNUSED: rd_data = UNUSED_BYTE;
			default:     rd_data = 8'h00;
		endcase
	end

	assign boot_off = boot_off_q;

endmodule

[rtl/core/handheld_memory_bus_decoder_top.sv]
// Top level of the handheld memory bus decoder: handshake, read-modify-write stage and result register.
//
// Channel   Direction  Handshake                     Payload
// access    in         start high while busy low     command, address, write_data, joypad_state
// result    out        done high for one cycle       target, target_write, target_address,
//                                                    target_data, read_data, read_valid,
//                                                    joypad_interrupt
//
// In the accept cycle of an item the address is decoded and the local
// memories are read; in the following cycle (busy high) the read data returns, the result
// is formed and any write-back lands in the memory at the end of that cycle.
// The result is shown with done in the cycle after, while the next item may already be taken.
// No new item is accepted while busy is high, that is while an item waits for its memory read.
// Reset clears the control state, the I/O register valid bits, the boot-ROM flag and sets
// the interrupt-enable register to all ones. The receiver cannot stall: a result is held
// for exactly one cycle.
module handheld_memory_bus_decoder_top
	import hmbd_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic        command,
	input  logic [15:0] address,
	input  logic [7:0]  write_data,
	input  logic [7:0]  joypad_state,
	output logic        done,
	output logic [2:0]  target,
	output logic        target_write,
	output logic [15:0] target_address,
	output logic [7:0]  target_data,
	output logic [7:0]  read_data,
	output logic        read_valid,
	output logic        joypad_interrupt
);

	logic       accept;
	logic       boot_off;
	dec_t       dec;
	logic [7:0] mem_rd;
	wr_req_t    wr;

	// Stage one holds the accepted item while its memory read completes.
	logic        vld_s1;
	logic        cmd_s1;
	logic [15:0] addr_s1;
	logic [7:0]  wd_s1;
	logic [7:0]  joy_s1;
	dec_t        dec_s1;

	// Result formed in stage one.
	logic        ext;
	logic        is_joy;
	logic [2:0]  tgt_c;
	logic        twr_c;
	logic [15:0] taddr_c;
	logic [7:0]  tdata_c;
	logic [7:0]  rd_c;
	logic        rv_c;
	logic        irq_c;

	logic        done_q;
	logic [2:0]  target_q;
	logic        target_write_q;
	logic [15:0] target_address_q;
	logic [7:0]  target_data_q;
	logic [7:0]  read_data_q;
	logic        read_valid_q;
	logic        joypad_interrupt_q;

	assign busy   = vld_s1;
	assign accept = start && !busy;

	hmbd_decode u_decode (
		.write    (command),
		.address  (address),
		.boot_off (boot_off),
		.dec      (dec)
	);

	hmbd_store u_store (
		.clk      (clk),
		.arst_n   (arst_n),
		.rd_en    (accept),
		.rd_area  (dec.area),
		.rd_idx   (dec.idx),
		.rd_data  (mem_rd),
		.wr       (wr),
		.boot_off (boot_off)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1  <= command;
			addr_s1 <= address;
			wd_s1   <= write_data;
			joy_s1  <= joypad_state;
			dec_s1  <= dec;
		end
	end

	// A read of the joypad register stores the fresh joypad byte and compares it
	// with the byte held before; every other local write stores the bus byte.
	always_comb begin
		ext     = (dec_s1.tgt != TGT_LOCAL) && (dec_s1.tgt != TGT_IGNORE);
		is_joy  = (dec_s1.tgt == TGT_LOCAL) && !cmd_s1 && (addr_s1 == JOYPAD_ADDR);
		tgt_c   = dec_s1.tgt;
		twr_c   = ext && cmd_s1;
		taddr_c = ext ? addr_s1 : 16'h0000;
		tdata_c = (ext && cmd_s1) ? wd_s1 : 8'h00;
		rv_c    = (dec_s1.tgt == TGT_LOCAL) && !cmd_s1;
		irq_c   = is_joy && (mem_rd > joy_s1);
		if (!rv_c) begin
			rd_c = 8'h00;
		end else if (is_joy) begin
			rd_c = joy_s1;
		end else begin
			rd_c = mem_rd;
		end

		wr.en   = vld_s1 && (dec_s1.tgt == TGT_LOCAL) && (cmd_s1 || is_joy)
			&& (dec_s1.area != AREA_UNUSED);
		wr.area = dec_s1.area;
		wr.idx  = dec_s1.idx;
		wr.data = cmd_s1 ? wd_s1 : joy_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (vld_s1) begin
			target_q           <= tgt_c;
			target_write_q     <= twr_c;
			target_address_q   <= taddr_c;
			target_data_q      <= tdata_c;
			read_data_q        <= rd_c;
			read_valid_q       <= rv_c;
			joypad_interrupt_q <= irq_c;
		end
	end

	assign done             = done_q;
	assign target           = target_q;
	assign target_write     = target_write_q;
	assign target_address   = target_address_q;
	assign target_data      = target_data_q;
	assign read_data        = read_data_q;
	assign read_valid       = read_valid_q;
	assign joypad_interrupt = joypad_interrupt_q;

	// An accepted item always yields a result: done follows after stage one.
	a_accept_done: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> ##1 done)
		else $error("accepted item produced no result");

	// A local read never forwards a write at the same time.
	a_read_excl: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !(read_valid && target_write))
		else $error("local read and forwarded write together");

	// The joypad interrupt only comes with a locally answered read.
	a_irq_local: assert property (@(posedge clk) disable iff (!arst_n)
		(done && joypad_interrupt) |-> (read_valid && target == TGT_LOCAL))
		else $error("joypad interrupt outside a local read");

	// Local and dropped accesses forward no address.
	a_no_fwd: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (target == TGT_LOCAL || target == TGT_IGNORE)) |->
		(target_address == 16'h0000 && !target_write))
		else $error("address forwarded for a local or dropped access");

endmodule
